// ===== rtl/sha1_hash_with_padding_assert.svh =====
// Assertion macros shared by the SHA-1 hasher checker.
// Needs no package; each macro expands to one concurrent assertion.
`ifndef SHA1_HASH_WITH_PADDING_ASSERT_SVH
`define SHA1_HASH_WITH_PADDING_ASSERT_SVH

// The expression must hold at every clock edge outside reset.
`define SHA1H_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("sha1h assertion failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define SHA1H_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha1h assertion failed");

// When the antecedent holds, the consequent holds in the same cycle.
`define SHA1H_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha1h assertion failed");

`endif

// ===== rtl/sha1h_pkg.sv =====
// Types and constants of the SHA-1 hasher with padding.
// Used by the round unit, the schedule window and the top level.
`default_nettype none

package sha1h_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0][31:0] hash_t;

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  // Index 0 is the most significant digest word.
  localparam hash_t HashInit = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                32'hEFCDAB89, 32'h67452301};

  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [6:0] LastRound = 7'd79;
  localparam logic [2:0] LastWord  = 3'd4;
  localparam logic [5:0] LastPos   = 6'd63;
  localparam logic [5:0] PreLenPos = 6'd55;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD80,
    ST_PADZ,
    ST_PADLEN,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic       push;
    logic [7:0] byte_val;
    logic       step;
  } sched_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sha1h_round.sv =====
// One SHA-1 round: round function, constant and five-input sum.
// Depends on sha1h_pkg for the round constants.
`default_nettype none

module sha1h_round (
  input  sha1h_pkg::hash_t   vars_i,
  input  sha1h_pkg::word_t   w_i,
  input  logic [6:0]         round_i,
  output sha1h_pkg::word_t   t_o
);

  sha1h_pkg::word_t a, b, c, d, e;
  sha1h_pkg::word_t f, k;

  assign a = vars_i[0];
  assign b = vars_i[1];
  assign c = vars_i[2];
  assign d = vars_i[3];
  assign e = vars_i[4];

  always_comb begin
    priority if (round_i < 7'd20) begin
      f = (b & c) | (~b & d);
      k = sha1h_pkg::K0;
    end else if (round_i < 7'd40) begin
      f = b ^ c ^ d;
      k = sha1h_pkg::K1;
    end else if (round_i < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = sha1h_pkg::K2;
    end else begin
      f = b ^ c ^ d;
      k = sha1h_pkg::K3;
    end
  end

  assign t_o = {a[26:0], a[31:27]} + f + e + k + w_i;

endmodule

`default_nettype wire

// ===== rtl/sha1h_sched.sv =====
// Sixteen-word block buffer that doubles as the SHA-1 message schedule.
// Bytes shift in big-endian; during rounds it shifts one word per step.
// Depends on sha1h_pkg for the control struct.
`default_nettype none

module sha1h_sched (
  input  logic                   clk_i,
  input  sha1h_pkg::sched_ctrl_t ctrl_i,
  output sha1h_pkg::word_t       w0_o
);

  sha1h_pkg::word_t w_q [16];
  sha1h_pkg::word_t w_d [16];
  sha1h_pkg::word_t mix;

  // The window holds W[t..t+15]; the appended word is W[t+16].
  assign mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      w_d[i] = w_q[i];
    end
    if (ctrl_i.push) begin
      for (int i = 0; i < 15; i++) begin
        w_d[i] = {w_q[i][23:0], w_q[i+1][31:24]};
      end
      w_d[15] = {w_q[15][23:0], ctrl_i.byte_val};
    end else if (ctrl_i.step) begin
      for (int i = 0; i < 15; i++) begin
        w_d[i] = w_q[i+1];
      end
      w_d[15] = {mix[30:0], mix[31]};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 16; i++) begin
      w_q[i] <= w_d[i];
    end
  end

  assign w0_o = w_q[0];

endmodule

`default_nettype wire

// ===== rtl/sha1_hash_with_padding.sv =====
// SHA-1 hasher with standard padding, top level.
// Depends on sha1h_pkg, sha1h_sched and sha1h_round.
//
// Usage: message bytes arrive on the slave stream, one item per byte.
// tdata carries the byte, tuser says the byte is valid, tlast ends the
// message (a byte flagged together with tlast is part of the message).
// The block accepts one byte per cycle until a 64-byte block fills; the
// block is then compressed by one shared round unit, one round per cycle,
// followed by an add step that folds the result into the chaining hash,
// during which tready is low. At the end of a message the padding bytes
// are shifted in one per cycle (up to 64, or up to 72 when a second block
// is needed) and each padded block is compressed in the same way.
// The digest then leaves on the master stream as five items: tdata is the
// word, tuser its index (0 is most significant), tlast marks the fifth.
// While the receiver stalls the word is held; no input is taken until all
// five words have been taken, after which the block is ready for the next
// message. Reset loads the standard initial hash, clears the byte count
// and leaves the block ready for input.
`default_nettype none

module sha1_hash_with_padding (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] byte_valid
  input  logic        s_axis_tlast_i,   // end_of_message
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser_o,   // [2:0] word_index
  output logic        m_axis_tlast_o    // last_word
);

  sha1h_pkg::state_e      state_q, state_d;
  sha1h_pkg::state_e      ret_q, ret_d;
  sha1h_pkg::hash_t       h_q;
  sha1h_pkg::hash_t       v_q;
  logic [60:0]            cnt_q;
  logic [5:0]             pos_q;
  logic [6:0]             round_q;
  logic [2:0]             idx_q;
  sha1h_pkg::sched_ctrl_t sched_ctrl;
  sha1h_pkg::word_t       w0;
  sha1h_pkg::word_t       t_sum;
  logic                   in_acc;
  logic                   out_acc;
  logic [63:0]            len_shift;

  assign in_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o & m_axis_tready_i;

  // Length bytes go out most significant first: byte 56 is bits 63:56.
  assign len_shift = {cnt_q, 3'b000} >> {~pos_q[2:0], 3'b000};

  sha1h_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .w0_o   (w0)
  );

  sha1h_round u_round (
    .vars_i  (v_q),
    .w_i     (w0),
    .round_i (round_q),
    .t_o     (t_sum)
  );

  // Next state and return point after a compression.
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    unique case (state_q)
      sha1h_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i && pos_q == sha1h_pkg::LastPos) begin
            state_d = sha1h_pkg::ST_ROUND;
            ret_d   = s_axis_tlast_i ? sha1h_pkg::ST_PAD80 : sha1h_pkg::ST_IDLE;
          end else if (s_axis_tlast_i) begin
            state_d = sha1h_pkg::ST_PAD80;
          end
        end
      end
      sha1h_pkg::ST_PAD80, sha1h_pkg::ST_PADZ: begin
        priority if (pos_q == sha1h_pkg::LastPos) begin
          state_d = sha1h_pkg::ST_ROUND;
          ret_d   = sha1h_pkg::ST_PADZ;
        end else if (pos_q == sha1h_pkg::PreLenPos) begin
          state_d = sha1h_pkg::ST_PADLEN;
        end else begin
          state_d = sha1h_pkg::ST_PADZ;
        end
      end
      sha1h_pkg::ST_PADLEN: begin
        if (pos_q == sha1h_pkg::LastPos) begin
          state_d = sha1h_pkg::ST_ROUND;
          ret_d   = sha1h_pkg::ST_OUT;
        end
      end
      sha1h_pkg::ST_ROUND: begin
        if (round_q == sha1h_pkg::LastRound) begin
          state_d = sha1h_pkg::ST_ADD;
        end
      end
      sha1h_pkg::ST_ADD: begin
        if (round_q[2:0] == sha1h_pkg::LastWord) begin
          state_d = ret_q;
        end
      end
      sha1h_pkg::ST_OUT: begin
        if (out_acc && idx_q == sha1h_pkg::LastWord) begin
          state_d = sha1h_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sha1h_pkg::ST_IDLE;
      end
    endcase
  end

  // Handshakes and schedule control.
  always_comb begin
    s_axis_tready_o     = 1'b0;
    m_axis_tvalid_o     = 1'b0;
    sched_ctrl.push     = 1'b0;
    sched_ctrl.byte_val = 8'h00;
    sched_ctrl.step     = 1'b0;
    unique case (state_q)
      sha1h_pkg::ST_IDLE: begin
        s_axis_tready_o     = 1'b1;
        sched_ctrl.push     = in_acc & s_axis_tuser_i;
        sched_ctrl.byte_val = s_axis_tdata_i;
      end
      sha1h_pkg::ST_PAD80: begin
        sched_ctrl.push     = 1'b1;
        sched_ctrl.byte_val = sha1h_pkg::PadMarker;
      end
      sha1h_pkg::ST_PADZ: begin
        sched_ctrl.push     = 1'b1;
      end
      sha1h_pkg::ST_PADLEN: begin
        sched_ctrl.push     = 1'b1;
        sched_ctrl.byte_val = len_shift[7:0];
      end
      sha1h_pkg::ST_ROUND: begin
        sched_ctrl.step     = 1'b1;
      end
      sha1h_pkg::ST_ADD: begin
      end
      sha1h_pkg::ST_OUT: begin
        m_axis_tvalid_o     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tdata_o = h_q[idx_q];
  assign m_axis_tuser_o = idx_q;
  assign m_axis_tlast_o = (idx_q == sha1h_pkg::LastWord);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha1h_pkg::ST_IDLE;
      ret_q   <= sha1h_pkg::ST_IDLE;
      h_q     <= sha1h_pkg::HashInit;
      cnt_q   <= '0;
      pos_q   <= '0;
      round_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      if (sched_ctrl.push) begin
        pos_q <= pos_q + 6'd1;
      end
      if (state_q == sha1h_pkg::ST_IDLE && sched_ctrl.push) begin
        cnt_q <= cnt_q + 61'd1;
      end
      if (state_q == sha1h_pkg::ST_ROUND) begin
        round_q <= (round_q == sha1h_pkg::LastRound) ? 7'd0 : round_q + 7'd1;
      end else if (state_q == sha1h_pkg::ST_ADD) begin
        round_q <= (round_q[2:0] == sha1h_pkg::LastWord) ? 7'd0 : round_q + 7'd1;
        // Rotate so that each word passes the single adder once.
        h_q     <= {h_q[0] + v_q[0], h_q[4:1]};
      end
      if (out_acc) begin
        if (idx_q == sha1h_pkg::LastWord) begin
          idx_q <= '0;
          h_q   <= sha1h_pkg::HashInit;
          cnt_q <= '0;
        end else begin
          idx_q <= idx_q + 3'd1;
        end
      end
    end
  end

  // Working variables a..e live in v_q[0..4].
  always_ff @(posedge clk_i) begin
    if (state_d == sha1h_pkg::ST_ROUND && state_q != sha1h_pkg::ST_ROUND) begin
      v_q <= h_q;
    end else if (state_q == sha1h_pkg::ST_ROUND) begin
      v_q <= {v_q[3], v_q[2], {v_q[1][1:0], v_q[1][31:2]}, v_q[0], t_sum};
    end else if (state_q == sha1h_pkg::ST_ADD) begin
      v_q <= {v_q[0], v_q[4:1]};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sha1h_checker.sv =====
// Port-level checker for the SHA-1 hasher, bound to the top level.
// Depends on sha1_hash_with_padding_assert.svh for the assertion macros
// and on sha1h_pkg for the index of the final word.
`default_nettype none

`include "sha1_hash_with_padding_assert.svh"

module sha1h_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  logic        out_acc;
  logic        mid_acc;
  logic        end_acc;
  logic        out_stall;
  logic        is_last_idx;
  logic        idx_follows;
  logic [2:0]  idx_inc_q;
  logic [34:0] out_word;

  assign out_acc     = m_axis_tvalid_o && m_axis_tready_i;
  assign mid_acc     = out_acc && !m_axis_tlast_o;
  assign end_acc     = out_acc && m_axis_tlast_o;
  assign out_stall   = m_axis_tvalid_o && !m_axis_tready_i;
  assign is_last_idx = (m_axis_tuser_o == sha1h_pkg::LastWord);
  assign idx_follows = m_axis_tvalid_o && (m_axis_tuser_o == idx_inc_q);
  assign out_word    = {m_axis_tuser_o, m_axis_tdata_o};

  // Index that the word after the current one has to carry.
  always_ff @(posedge clk_i) begin
    idx_inc_q <= m_axis_tuser_o + 3'd1;
  end

  // Input is never taken while a digest is being delivered.
  `SHA1H_ASSERT_ALWAYS(a_no_overlap, clk_i, rst_ni, !(s_axis_tready_o && m_axis_tvalid_o))

  // The final flag goes with the fifth word and no other.
  `SHA1H_ASSERT_SAME(a_last_idx, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tlast_o == is_last_idx)

  // Words leave in order, each index one above the previous.
  `SHA1H_ASSERT_NEXT(a_idx_step, clk_i, rst_ni, mid_acc, idx_follows)

  // After the last word the block is ready for a new message.
  `SHA1H_ASSERT_NEXT(a_ready_after, clk_i, rst_ni, end_acc, s_axis_tready_o)

  // A stalled word holds.
  `SHA1H_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_o && $stable(out_word))

endmodule

bind sha1_hash_with_padding sha1h_checker u_sha1h_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire
